FILE: design/assert_macros.svh
// Assertion helpers used by utf8d_checker in the design folder.
// Each macro takes a label, a clock, an active-low reset and the two sides
// of an implication.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: design/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Constants shared by the UTF-8 code point decoder and its checker.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int CfgIndexW = 2;

	// Configuration register indexes.
	localparam logic [CfgIndexW-1:0] REG_HALFWIDTH_FIRST = 2'd0;
	localparam logic [CfgIndexW-1:0] REG_HALFWIDTH_COUNT = 2'd1;

	localparam logic [7:0] HALFWIDTH_FIRST_RST = 8'd32;
	localparam logic [7:0] HALFWIDTH_COUNT_RST = 8'd95;

	// Special code points.
	localparam logic [15:0] CP_REPLACEMENT = 16'hFFFD;
	localparam logic [15:0] CP_BEYOND      = 16'hFFFF;
	localparam logic [15:0] CP_MIN_TWO     = 16'h0080;
	localparam logic [15:0] CP_MIN_THREE   = 16'h0800;

	// Display cell widths.
	localparam logic [1:0] WIDTH_NONE = 2'd0;
	localparam logic [1:0] WIDTH_HALF = 2'd1;
	localparam logic [1:0] WIDTH_FULL = 2'd2;

	// Form lengths in bytes.
	localparam logic [2:0] LEN_NONE  = 3'd0;
	localparam logic [2:0] LEN_ONE   = 3'd1;
	localparam logic [2:0] LEN_TWO   = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR  = 3'd4;

endpackage

FILE: design/utf8_codepoint_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_unit
// Decodes a UTF-8 byte stream into 16-bit code points with byte counts and
// display cell widths, flagging invalid bytes with U+FFFD.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   -------   -------------------   ----------------------------------------
//   cfg       cfg_valid/cfg_ready   cfg_index, cfg_data
//   in        in_valid/in_ready     text_byte
//   out       out_valid/out_ready   code_point, bytes_used, cell_width,
//                                   end_of_text, last_of_run
//
// An input byte is decoded in the cycle of its transfer and its results land
// in a result register; the first result is offered on the next cycle.
// A byte that yields one result or none leaves the input ready while
// out_ready holds, so clean text flows at one byte per cycle. A byte that
// breaks a held form yields up to four results, which leave the result
// register one per cycle while out_ready holds; the input stalls until the
// last result of the run transfers, and is taken again in that same cycle.
// Reset clears the held form and the result register and restores the
// half-width range to its defaults. The configuration port is always ready.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration writes.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [utf8d_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [7:0]                      cfg_data,
	// Input bytes.
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      text_byte,
	// Results.
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [15:0]                     code_point,
	output logic [2:0]                      bytes_used,
	output logic [1:0]                      cell_width,
	output logic                            end_of_text,
	output logic                            last_of_run
);

	// Half-width range registers.
	logic [7:0]  hw_first_q;
	logic [7:0]  hw_count_q;

	// The partially received form: lead byte, payload of the continuation
	// bytes seen so far, and number of held bytes including the lead.
	logic [7:0]  held_lead_q;
	logic [11:0] held_payload_q;
	logic [1:0]  held_count_q;

	// Result register. A run is some replacement characters for held bytes
	// (rep_q of them), optionally followed by one final result (the tail).
	logic [1:0]  rep_q;
	logic        tail_q;
	logic [15:0] tail_cp_q;
	logic [2:0]  tail_used_q;
	logic [1:0]  tail_width_q;
	logic        tail_eot_q;

	// Decode of a byte as if nothing were held.
	logic        f_tail;
	logic [15:0] f_cp;
	logic [2:0]  f_used;
	logic        f_eot;
	logic        f_hold;

	// Decode of the byte against the held form.
	logic        is_cont;
	logic [2:0]  need;
	logic [2:0]  have;
	logic [15:0] cp_two;
	logic [15:0] cp_three;

	logic [1:0]  nx_rep;
	logic        nx_tail;
	logic [15:0] nx_cp;
	logic [2:0]  nx_used;
	logic        nx_eot;
	logic [1:0]  nx_width;
	logic [7:0]  nx_lead;
	logic [11:0] nx_payload;
	logic [1:0]  nx_count;

	logic [8:0]  hw_end;
	logic        in_xfer;
	logic        out_xfer;

	assign cfg_ready = 1'b1;

	// ------------------------------------------------------------------
	// Fresh byte decode: end marker, ASCII, a lead to hold, or a stray byte.
	// ------------------------------------------------------------------
	always_comb begin
		f_tail = 1'b1;
		f_cp   = utf8d_pkg::CP_REPLACEMENT;
		f_used = utf8d_pkg::LEN_ONE;
		f_eot  = 1'b0;
		f_hold = 1'b0;
		if (text_byte == 8'h00) begin
			f_cp   = 16'h0000;
			f_used = utf8d_pkg::LEN_NONE;
			f_eot  = 1'b1;
		end else if (!text_byte[7]) begin
			f_cp = {8'h00, text_byte};
		end else if (text_byte[7:5] == 3'b110 || text_byte[7:4] == 4'b1110 ||
			     text_byte[7:3] == 5'b11110) begin
			f_tail = 1'b0;
			f_hold = 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Continuation handling against the held form.
	// ------------------------------------------------------------------
	assign is_cont = (text_byte[7:6] == 2'b10);
	assign have    = {1'b0, held_count_q} + 3'd1;
	assign cp_two  = {5'b00000, held_lead_q[4:0], text_byte[5:0]};
	assign cp_three = {held_lead_q[3:0], held_payload_q[5:0], text_byte[5:0]};

	always_comb begin
		if (held_lead_q[7:5] == 3'b110) begin
			need = utf8d_pkg::LEN_TWO;
		end else if (held_lead_q[7:4] == 4'b1110) begin
			need = utf8d_pkg::LEN_THREE;
		end else begin
			need = utf8d_pkg::LEN_FOUR;
		end
	end

	always_comb begin
		nx_rep     = 2'd0;
		nx_tail    = 1'b0;
		nx_cp      = utf8d_pkg::CP_REPLACEMENT;
		nx_used    = utf8d_pkg::LEN_ONE;
		nx_eot     = 1'b0;
		nx_lead    = held_lead_q;
		nx_payload = held_payload_q;
		nx_count   = held_count_q;

		if (held_count_q == 2'd0) begin
			nx_tail = f_tail;
			nx_cp   = f_cp;
			nx_used = f_used;
			nx_eot  = f_eot;
			if (f_hold) begin
				nx_lead    = text_byte;
				nx_payload = 12'h000;
				nx_count   = 2'd1;
			end
		end else if (is_cont) begin
			if (have < need) begin
				// Form still incomplete: shift in six more payload bits.
				nx_payload = {held_payload_q[5:0], text_byte[5:0]};
				nx_count   = have[1:0];
			end else begin
				nx_lead    = 8'h00;
				nx_payload = 12'h000;
				nx_count   = 2'd0;
				if (need == utf8d_pkg::LEN_TWO) begin
					if (cp_two >= utf8d_pkg::CP_MIN_TWO) begin
						nx_tail = 1'b1;
						nx_cp   = cp_two;
						nx_used = utf8d_pkg::LEN_TWO;
					end else begin
						nx_rep = 2'd2;
					end
				end else if (need == utf8d_pkg::LEN_THREE) begin
					if (cp_three >= utf8d_pkg::CP_MIN_THREE) begin
						nx_tail = 1'b1;
						nx_cp   = cp_three;
						nx_used = utf8d_pkg::LEN_THREE;
					end else begin
						nx_rep = 2'd3;
					end
				end else begin
					nx_tail = 1'b1;
					nx_cp   = utf8d_pkg::CP_BEYOND;
					nx_used = utf8d_pkg::LEN_FOUR;
				end
			end
		end else begin
			// Broken form: every held byte becomes a replacement character,
			// then the new byte is decoded on a clean slate.
			nx_rep  = held_count_q;
			nx_tail = f_tail;
			nx_cp   = f_cp;
			nx_used = f_used;
			nx_eot  = f_eot;
			if (f_hold) begin
				nx_lead    = text_byte;
				nx_payload = 12'h000;
				nx_count   = 2'd1;
			end else begin
				nx_lead    = 8'h00;
				nx_payload = 12'h000;
				nx_count   = 2'd0;
			end
		end
	end

	// Cell width of the tail result. The range end is nine bits wide, so the
	// replacement and beyond-plane code points always fall outside it.
	assign hw_end = {1'b0, hw_first_q} + {1'b0, hw_count_q};

	always_comb begin
		if (nx_eot) begin
			nx_width = utf8d_pkg::WIDTH_NONE;
		end else if (nx_cp >= {8'h00, hw_first_q} && nx_cp < {7'h00, hw_end}) begin
			nx_width = utf8d_pkg::WIDTH_HALF;
		end else begin
			nx_width = utf8d_pkg::WIDTH_FULL;
		end
	end

	// ------------------------------------------------------------------
	// Output side: replacement characters first, then the tail.
	// ------------------------------------------------------------------
	assign out_valid   = (rep_q != 2'd0) || tail_q;
	assign last_of_run = (rep_q == 2'd0) || ((rep_q == 2'd1) && !tail_q);
	assign code_point  = (rep_q != 2'd0) ? utf8d_pkg::CP_REPLACEMENT : tail_cp_q;
	assign bytes_used  = (rep_q != 2'd0) ? utf8d_pkg::LEN_ONE : tail_used_q;
	assign cell_width  = (rep_q != 2'd0) ? utf8d_pkg::WIDTH_FULL : tail_width_q;
	assign end_of_text = (rep_q == 2'd0) && tail_eot_q;

	// A new byte may enter when the result register is empty or is handing
	// over its last result in this cycle.
	assign in_ready = !out_valid || (out_ready && last_of_run);
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_first_q     <= utf8d_pkg::HALFWIDTH_FIRST_RST;
			hw_count_q     <= utf8d_pkg::HALFWIDTH_COUNT_RST;
			held_lead_q    <= 8'h00;
			held_payload_q <= 12'h000;
			held_count_q   <= 2'd0;
			rep_q          <= 2'd0;
			tail_q         <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					utf8d_pkg::REG_HALFWIDTH_FIRST: hw_first_q <= cfg_data;
					utf8d_pkg::REG_HALFWIDTH_COUNT: hw_count_q <= cfg_data;
					default: ;
				endcase
			end

			if (in_xfer) begin
				held_lead_q    <= nx_lead;
				held_payload_q <= nx_payload;
				held_count_q   <= nx_count;
				rep_q          <= nx_rep;
				tail_q         <= nx_tail;
			end else if (out_xfer) begin
				if (rep_q != 2'd0) begin
					rep_q <= rep_q - 2'd1;
				end else begin
					tail_q <= 1'b0;
				end
			end
		end
	end

	// Tail payload needs no reset.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			tail_cp_q    <= nx_cp;
			tail_used_q  <= nx_used;
			tail_width_q <= nx_width;
			tail_eot_q   <= nx_eot;
		end
	end

endmodule

FILE: design/utf8d_checker.sv
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks on the result channel of the UTF-8 code point decoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] code_point,
	input logic [2:0]  bytes_used,
	input logic [1:0]  cell_width,
	input logic        end_of_text,
	input logic        last_of_run
);

	// A stalled result holds its value.
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(code_point) && $stable(bytes_used))

	// The end marker has a fixed shape and always closes its run.
	`ASSERT_SAME(a_eot_shape, clk, arst_n, out_valid && end_of_text, code_point == 16'h0000 && bytes_used == utf8d_pkg::LEN_NONE && cell_width == utf8d_pkg::WIDTH_NONE && last_of_run)

	// Only a replacement for a single byte can be followed by more results.
	`ASSERT_SAME(a_mid_run_repl, clk, arst_n, out_valid && !last_of_run, code_point == utf8d_pkg::CP_REPLACEMENT && bytes_used == utf8d_pkg::LEN_ONE && !end_of_text)

	// A result that is not the last of its run is followed at once by another.
	`ASSERT_NEXT(a_run_continues, clk, arst_n, out_valid && out_ready && !last_of_run, out_valid)

	// A four-byte form always reads as the beyond-plane marker at full width.
	`ASSERT_SAME(a_four_byte, clk, arst_n, out_valid && bytes_used == utf8d_pkg::LEN_FOUR, code_point == utf8d_pkg::CP_BEYOND && cell_width == utf8d_pkg::WIDTH_FULL)

endmodule

bind utf8_codepoint_decoder_unit utf8d_checker u_utf8d_checker (.*);
